FILE: rtl/core/spwm_pkg.sv
// Shared types and constants for the servo pulse block with nibble command link.
// No dependencies; used by the top level and its port checker.
package spwm_pkg;

    localparam int CNT_W   = 16;
    localparam int ANGLE_W = 8;
    localparam int NIB_W   = 4;
    localparam int PWM_W   = 3;
    localparam int CLAW_W  = 2;
    localparam int DB_W    = 7;
    localparam int STEP_W  = 7;
    localparam int DIV_W   = 4;
    localparam int REG_IDX_W = 3;
    localparam int PHASE_W = 2;

    // register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_TOP    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_OFFSET  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_LIMIT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEADBAND      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SLEW_STEP     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SLEW_INTERVAL = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_QUIET_LOW     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_QUIET_HIGH    = 3'd7;

    // register reset values
    localparam logic [CNT_W-1:0]  RST_PERIOD_TOP    = 16'd19999;
    localparam logic [CNT_W-1:0]  RST_PULSE_OFFSET  = 16'd400;
    localparam logic [CNT_W-1:0]  RST_PULSE_LIMIT   = 16'd2200;
    localparam logic [DB_W-1:0]   RST_DEADBAND      = 7'd7;
    localparam logic [STEP_W-1:0] RST_SLEW_STEP     = 7'd10;
    localparam logic [DIV_W-1:0]  RST_SLEW_INTERVAL = 4'd10;
    localparam logic [CNT_W-1:0]  RST_QUIET_LOW     = 16'd300;
    localparam logic [CNT_W-1:0]  RST_QUIET_HIGH    = 16'd2300;

    localparam logic [ANGLE_W-1:0] ANGLE_CENTER = 8'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_ZERO   = 8'd0;
    localparam logic [ANGLE_W-1:0] TARGET_MAX   = 8'd180;
    localparam int                 PULSE_SCALE  = 10;

    localparam logic [NIB_W-1:0] NIB_STROBE  = 4'b1100;
    localparam logic [NIB_W-1:0] NIB_LOW     = 4'b0011;
    localparam logic [NIB_W-1:0] CAPTURE_RST = 4'b1111;

    // link phases
    localparam logic [PHASE_W-1:0] PH_YAW    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ROLL   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_CLAW   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_UNUSED = 2'd3;

    // claw events
    localparam logic [CLAW_W-1:0] CLAW_NONE  = 2'd0;
    localparam logic [CLAW_W-1:0] CLAW_OPEN  = 2'd1;
    localparam logic [CLAW_W-1:0] CLAW_CLOSE = 2'd2;
    localparam logic [CLAW_W-1:0] CLAW_EMPTY = 2'd3;

    typedef struct packed {
        logic [PWM_W-1:0]  pwm_levels;
        logic [CLAW_W-1:0] claw_event;
        logic              frame_error;
    } res_t;

endpackage

FILE: rtl/core/servo_pwm_with_nibble_command_link_top.sv
// Results are registered in out_reg, or in skid_reg while out_reg's beat is stalled.
// Throughput: one tick per cycle while in_stall is low; a one-beat skid register
// keeps input open while a result waits, so in_stall rises only when both output
// and skid hold a beat. Reset (rst_n low, asynchronous) restores all registers but
// out_reg and skid_reg, angles {0,90,...}, targets 90, link phase idle and capture
// all ones. No clearing pass. Depends on spwm_pkg.
module servo_pwm_with_nibble_command_link_top #(
    parameter int SERVO_COUNT = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [spwm_pkg::NIB_W-1:0]        port_nibble,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [spwm_pkg::PWM_W-1:0]        pwm_levels,
    output logic [spwm_pkg::CLAW_W-1:0]       claw_event,
    output logic                              frame_error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spwm_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [spwm_pkg::CNT_W-1:0]        cfg_data
);
    import spwm_pkg::*;

    localparam int LANE_W = (SERVO_COUNT > PWM_W) ? SERVO_COUNT : PWM_W;
    localparam int WIDE_W = CNT_W + 1;
    localparam int SL_W   = ANGLE_W + 3;

    // configuration
    logic [CNT_W-1:0]  period_top_reg, pulse_offset_reg, pulse_limit_reg;
    logic [CNT_W-1:0]  quiet_low_reg, quiet_high_reg;
    logic [DB_W-1:0]   deadband_reg;
    logic [STEP_W-1:0] slew_step_reg;
    logic [DIV_W-1:0]  slew_interval_reg;

    // block state
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [DIV_W-1:0]       div_reg, div_next;
    logic [ANGLE_W-1:0]     angle_reg [SERVO_COUNT];
    logic [ANGLE_W-1:0]     angle_next [SERVO_COUNT];
    logic [ANGLE_W-1:0]     target_reg [SERVO_COUNT];
    logic [ANGLE_W-1:0]     target_next [SERVO_COUNT];
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [NIB_W-1:0]       capture_reg, capture_next;
    logic [SERVO_COUNT-1:0] pin_reg, pin_next;

    // output queue
    res_t out_reg, skid_reg, res_next;
    logic out_valid_reg, skid_valid_reg;

    logic              accept, take;
    logic              strobe, in_window, period_end, do_slew;
    logic [DIV_W-1:0]  div_inc;
    logic [LANE_W-1:0] nudge_up, nudge_dn, pin_pad;
    logic              err;
    logic [CLAW_W-1:0] claw;

    function automatic logic [ANGLE_W-1:0] slew_one(
        input logic [ANGLE_W-1:0] a,
        input logic [ANGLE_W-1:0] t,
        input logic [DB_W-1:0]    db,
        input logic [STEP_W-1:0]  st
    );
        logic signed [SL_W-1:0] a_s, t_lo, t_hi, st_s, a1, a2;
        logic [ANGLE_W-1:0]     r;
        a_s  = signed'(SL_W'(a));
        st_s = signed'(SL_W'(st));
        t_lo = signed'(SL_W'(t)) - signed'(SL_W'(db));
        t_hi = signed'(SL_W'(t)) + signed'(SL_W'(db));
        a1 = (a_s < t_lo) ? a_s + st_s : a_s;
        a2 = (a1 > t_hi) ? a1 - st_s : a1;
        if (a2 < 0)
        begin
            r = '0;
        end
        else if (a2 > signed'(SL_W'({ANGLE_W{1'b1}})))
        begin
            r = '1;
        end
        else
        begin
            r = a2[ANGLE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ANGLE_W-1:0] nudge(
        input logic [ANGLE_W-1:0] t,
        input logic               up,
        input logic               dn
    );
        logic [ANGLE_W-1:0] r;
        r = t;
        if (up)
        begin
            r = (t >= TARGET_MAX) ? TARGET_MAX : t + 1'b1;
        end
        else if (dn)
        begin
            r = (t == ANGLE_ZERO) ? ANGLE_ZERO : t - 1'b1;
        end
        return r;
    endfunction

    assign take      = out_valid_reg && !out_stall;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = skid_valid_reg;
    assign cfg_ready = 1'b1;

    assign strobe     = (port_nibble & NIB_STROBE) == NIB_STROBE;
    assign in_window  = (count_reg >= quiet_low_reg) && (count_reg <= quiet_high_reg);
    assign period_end = count_reg >= period_top_reg;
    assign div_inc    = div_reg + 1'b1;
    assign do_slew    = period_end && (div_inc >= slew_interval_reg);

    // command link decode, only outside the active window
    always_comb
    begin
        phase_next   = phase_reg;
        capture_next = capture_reg;
        err          = 1'b0;
        claw         = CLAW_NONE;
        nudge_up     = '0;
        nudge_dn     = '0;
        if (!in_window)
        begin
            case (phase_reg)
                PH_YAW:
                begin
                    if (strobe)
                    begin
                        if ((port_nibble & NIB_LOW) == NIB_LOW)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            phase_next  = PH_ROLL;
                            nudge_up[0] = port_nibble[1];
                            nudge_dn[0] = !port_nibble[1] && port_nibble[0];
                        end
                    end
                end
                PH_ROLL:
                begin
                    if (!strobe)
                    begin
                        if ((port_nibble & NIB_LOW) == NIB_LOW)
                        begin
                            err          = 1'b1;
                            capture_next = CAPTURE_RST;
                            phase_next   = PH_YAW;
                        end
                        else
                        begin
                            capture_next = port_nibble;
                            phase_next   = PH_CLAW;
                            nudge_up[1]  = port_nibble[3];
                            nudge_dn[1]  = !port_nibble[3] && port_nibble[2];
                            nudge_up[2]  = port_nibble[1];
                            nudge_dn[2]  = !port_nibble[1] && port_nibble[0];
                        end
                    end
                end
                PH_CLAW:
                begin
                    if (strobe || ((port_nibble & NIB_LOW) != NIB_LOW))
                    begin
                        err        = 1'b1;
                        phase_next = PH_YAW;
                    end
                    else if (port_nibble != capture_reg)
                    begin
                        capture_next = CAPTURE_RST;
                        phase_next   = PH_YAW;
                        if (port_nibble[3])
                        begin
                            claw = CLAW_OPEN;
                        end
                        else if (port_nibble[2])
                        begin
                            claw = CLAW_CLOSE;
                        end
                        else
                        begin
                            claw = CLAW_EMPTY;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_YAW;
                end
            endcase
        end
    end

    // pins, targets, slew and period counter
    always_comb
    begin
        logic [WIDE_W-1:0] w_raw;
        logic [CNT_W-1:0]  w_clip;
        pin_next = (count_reg == '0) ? '1 : pin_reg;
        for (int i = 0; i < SERVO_COUNT; i++)
        begin
            w_raw  = WIDE_W'(pulse_offset_reg) + WIDE_W'(angle_reg[i]) * WIDE_W'(PULSE_SCALE);
            w_clip = (w_raw > WIDE_W'(pulse_limit_reg)) ? pulse_limit_reg : w_raw[CNT_W-1:0];
            if (in_window && (count_reg >= w_clip))
            begin
                pin_next[i] = 1'b0;
            end
            target_next[i] = nudge(target_reg[i], nudge_up[i], nudge_dn[i]);
            angle_next[i]  = do_slew ?
                slew_one(angle_reg[i], target_next[i], deadband_reg, slew_step_reg) :
                angle_reg[i];
        end
        if (period_end)
        begin
            count_next = '0;
            div_next   = do_slew ? '0 : div_inc;
        end
        else
        begin
            count_next = count_reg + 1'b1;
            div_next   = div_reg;
        end
    end

    assign pin_pad              = LANE_W'(pin_next);
    assign res_next.pwm_levels  = pin_pad[PWM_W-1:0];
    assign res_next.claw_event  = claw;
    assign res_next.frame_error = err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_top_reg    <= RST_PERIOD_TOP;
            pulse_offset_reg  <= RST_PULSE_OFFSET;
            pulse_limit_reg   <= RST_PULSE_LIMIT;
            deadband_reg      <= RST_DEADBAND;
            slew_step_reg     <= RST_SLEW_STEP;
            slew_interval_reg <= RST_SLEW_INTERVAL;
            quiet_low_reg     <= RST_QUIET_LOW;
            quiet_high_reg    <= RST_QUIET_HIGH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PERIOD_TOP:    period_top_reg    <= cfg_data;
                REG_PULSE_OFFSET:  pulse_offset_reg  <= cfg_data;
                REG_PULSE_LIMIT:   pulse_limit_reg   <= cfg_data;
                REG_DEADBAND:      deadband_reg      <= cfg_data[DB_W-1:0];
                REG_SLEW_STEP:     slew_step_reg     <= cfg_data[STEP_W-1:0];
                REG_SLEW_INTERVAL: slew_interval_reg <= cfg_data[DIV_W-1:0];
                REG_QUIET_LOW:     quiet_low_reg     <= cfg_data;
                REG_QUIET_HIGH:    quiet_high_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            div_reg     <= '0;
            phase_reg   <= PH_YAW;
            capture_reg <= CAPTURE_RST;
            pin_reg     <= '0;
            for (int i = 0; i < SERVO_COUNT; i++)
            begin
                angle_reg[i]  <= (i == 0) ? ANGLE_ZERO : ANGLE_CENTER;
                target_reg[i] <= ANGLE_CENTER;
            end
        end
        else if (accept)
        begin
            count_reg   <= count_next;
            div_reg     <= div_next;
            phase_reg   <= phase_next;
            capture_reg <= capture_next;
            pin_reg     <= pin_next;
            for (int i = 0; i < SERVO_COUNT; i++)
            begin
                angle_reg[i]  <= angle_next[i];
                target_reg[i] <= target_next[i];
            end
        end
    end

    // output register with one skid beat behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pwm_levels  = out_reg.pwm_levels;
    assign claw_event  = out_reg.claw_event;
    assign frame_error = out_reg.frame_error;

endmodule

FILE: rtl/core/spwm_chk.sv
// Port checker for the servo pulse block, bound onto the top level.
// Depends on spwm_pkg and the top level's port names.
module spwm_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [spwm_pkg::PWM_W-1:0]     pwm_levels,
    input logic [spwm_pkg::CLAW_W-1:0]    claw_event,
    input logic                           frame_error
);
    import spwm_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pwm_levels)
            && $stable(claw_event) && $stable(frame_error))
        else $error("stalled result changed");

    // input backs up only behind a held result
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // drain the skid beat as soon as the output moves
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall && out_valid)
        else $error("skid beat not drained");

    // a rejected frame never carries a claw event
    a_err_no_claw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_error && (claw_event != CLAW_NONE)))
        else $error("claw event on rejected frame");

endmodule

bind servo_pwm_with_nibble_command_link_top spwm_chk u_spwm_chk (.*);

FILE: tb/servo_pwm_with_nibble_command_link_top_tb.sv
// Testbench for servo_pwm_with_nibble_command_link_top: directed link frames, then random
// ticks under several register settings and idle patterns, checked against a tick predictor.
// Depends on spwm_pkg and the top level only.
`timescale 1ns / 1ps

module servo_pwm_with_nibble_command_link_top_tb;
    import spwm_pkg::*;

    localparam int SERVOS          = 3;
    localparam int STUCK_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 170;
    localparam int DIRECTED_COUNT  = 24;

    typedef enum int {
        SETUP_RANDOM,
        SETUP_MIN,
        SETUP_MAX,
        SETUP_EMPTY_WINDOW
    } setup_t;

    typedef struct packed {
        logic [NIB_W-1:0] nib;
        logic             known;
        res_t             res;
    } tick_row_t;

    localparam res_t NO_RES = '0;

    // Reset settings leave counts below 300 outside the window: all pins high, link live.
    localparam tick_row_t DIRECTED_TICKS [DIRECTED_COUNT] = '{
        '{4'b1110, 1'b0, NO_RES},
        '{4'b1010, 1'b0, NO_RES},
        '{4'b1011, 1'b1, '{3'b111, CLAW_OPEN, 1'b0}},
        '{4'b1111, 1'b1, '{3'b111, CLAW_NONE, 1'b1}},
        '{4'b1101, 1'b0, NO_RES},
        '{4'b0101, 1'b0, NO_RES},
        '{4'b0111, 1'b1, '{3'b111, CLAW_CLOSE, 1'b0}},
        '{4'b1100, 1'b1, '{3'b111, CLAW_NONE, 1'b0}},
        '{4'b0011, 1'b1, '{3'b111, CLAW_NONE, 1'b1}},
        '{4'b1100, 1'b1, '{3'b111, CLAW_NONE, 1'b0}},
        '{4'b0000, 1'b1, '{3'b111, CLAW_NONE, 1'b0}},
        '{4'b0011, 1'b1, '{3'b111, CLAW_EMPTY, 1'b0}},
        '{4'b1100, 1'b1, '{3'b111, CLAW_NONE, 1'b0}},
        '{4'b1100, 1'b0, NO_RES},
        '{4'b0001, 1'b0, NO_RES},
        '{4'b0001, 1'b1, '{3'b111, CLAW_NONE, 1'b1}},
        '{4'b1100, 1'b0, NO_RES},
        '{4'b1000, 1'b0, NO_RES},
        '{4'b1100, 1'b1, '{3'b111, CLAW_NONE, 1'b1}},
        '{4'b0000, 1'b1, '{3'b111, CLAW_NONE, 1'b0}},
        '{4'b1110, 1'b0, NO_RES},
        '{4'b0110, 1'b0, NO_RES},
        '{4'b1111, 1'b1, '{3'b111, CLAW_NONE, 1'b1}},
        '{4'b1100, 1'b0, NO_RES}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [NIB_W-1:0]     port_nibble;
    logic                 out_valid;
    logic                 out_stall;
    logic [PWM_W-1:0]     pwm_levels;
    logic [CLAW_W-1:0]    claw_event;
    logic                 frame_error;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    // predictor state
    logic [CNT_W-1:0]   cnt_m;
    logic [DIV_W-1:0]   div_m;
    logic [ANGLE_W-1:0] angle_m [SERVOS];
    logic [ANGLE_W-1:0] target_m [SERVOS];
    logic [PHASE_W-1:0] phase_m;
    logic [NIB_W-1:0]   capture_m;
    logic [PWM_W-1:0]   pins_m;

    // predictor copy of the registers
    logic [CNT_W-1:0]  top_c;
    logic [CNT_W-1:0]  offset_c;
    logic [CNT_W-1:0]  limit_c;
    logic [DB_W-1:0]   db_c;
    logic [STEP_W-1:0] step_c;
    logic [DIV_W-1:0]  intv_c;
    logic [CNT_W-1:0]  qlow_c;
    logic [CNT_W-1:0]  qhigh_c;

    res_t pending_tick_results [$];
    int   bad_beats;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_go;

    servo_pwm_with_nibble_command_link_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .port_nibble (port_nibble),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pwm_levels  (pwm_levels),
        .claw_event  (claw_event),
        .frame_error (frame_error),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic reset_servo_model();
        int i;
        top_c    = RST_PERIOD_TOP;
        offset_c = RST_PULSE_OFFSET;
        limit_c  = RST_PULSE_LIMIT;
        db_c     = RST_DEADBAND;
        step_c   = RST_SLEW_STEP;
        intv_c   = RST_SLEW_INTERVAL;
        qlow_c   = RST_QUIET_LOW;
        qhigh_c  = RST_QUIET_HIGH;
        cnt_m    = '0;
        div_m    = '0;
        for (i = 0; i < SERVOS; i++)
        begin
            angle_m[i]  = (i == 0) ? ANGLE_ZERO : ANGLE_CENTER;
            target_m[i] = ANGLE_CENTER;
        end
        phase_m   = PH_YAW;
        capture_m = CAPTURE_RST;
        pins_m    = '0;
    endtask

    function automatic int pulse_width(input logic [ANGLE_W-1:0] angle);
        int w;
        w = int'(offset_c) + int'(angle) * PULSE_SCALE;
        if (w > int'(limit_c))
            w = int'(limit_c);
        return w;
    endfunction

    task automatic nudge_target(input int idx, input int dir);
        int t;
        t = int'(target_m[idx]) + dir;
        if (t < 0)
            t = 0;
        if (t > int'(TARGET_MAX))
            t = int'(TARGET_MAX);
        target_m[idx] = ANGLE_W'(t);
    endtask

    task automatic slew_angles();
        int i;
        int a;
        int t;
        for (i = 0; i < SERVOS; i++)
        begin
            a = int'(angle_m[i]);
            t = int'(target_m[i]);
            if (a < t - int'(db_c))
                a += int'(step_c);
            if (a > t + int'(db_c))
                a -= int'(step_c);
            if (a < 0)
                a = 0;
            if (a > 255)
                a = 255;
            angle_m[i] = ANGLE_W'(a);
        end
    endtask

    // One microsecond tick: pin levels, link decode, then period end and slew.
    task automatic step_servo_tick(input logic [NIB_W-1:0] nib, output res_t r);
        int i;
        logic [CNT_W-1:0]  c;
        logic              strobe;
        logic              pair_full;
        logic [CLAW_W-1:0] claw;
        logic              err;
        c         = cnt_m;
        claw      = CLAW_NONE;
        err       = 1'b0;
        strobe    = (nib & NIB_STROBE) == NIB_STROBE;
        pair_full = (nib & NIB_LOW) == NIB_LOW;
        if (c == '0)
            pins_m = '1;
        if (c >= qlow_c && c <= qhigh_c)
        begin
            for (i = 0; i < SERVOS; i++)
                if (int'(c) >= pulse_width(angle_m[i]))
                    pins_m[i] = 1'b0;
        end
        else
        begin
            case (phase_m)
                PH_YAW:
                begin
                    if (strobe)
                    begin
                        phase_m = PH_ROLL;
                        if (pair_full)
                        begin
                            err     = 1'b1;
                            phase_m = PH_YAW;
                        end
                        else if (nib[1])
                            nudge_target(0, 1);
                        else if (nib[0])
                            nudge_target(0, -1);
                    end
                end
                PH_ROLL:
                begin
                    if (!strobe)
                    begin
                        phase_m = PH_CLAW;
                        if (pair_full)
                        begin
                            err       = 1'b1;
                            capture_m = CAPTURE_RST;
                            phase_m   = PH_YAW;
                        end
                        else
                        begin
                            capture_m = nib;
                            if (nib[3])
                                nudge_target(1, 1);
                            else if (nib[2])
                                nudge_target(1, -1);
                            if (nib[1])
                                nudge_target(2, 1);
                            else if (nib[0])
                                nudge_target(2, -1);
                        end
                    end
                end
                PH_CLAW:
                begin
                    if (strobe || !pair_full)
                    begin
                        err     = 1'b1;
                        phase_m = PH_YAW;
                    end
                    else if (nib != capture_m)
                    begin
                        capture_m = CAPTURE_RST;
                        phase_m   = PH_YAW;
                        claw      = nib[3] ? CLAW_OPEN : (nib[2] ? CLAW_CLOSE : CLAW_EMPTY);
                    end
                end
                default:
                    phase_m = PH_YAW;
            endcase
        end
        if (c >= top_c)
        begin
            cnt_m = '0;
            div_m = div_m + 1'b1;
            if (div_m >= intv_c)
            begin
                slew_angles();
                div_m = '0;
            end
        end
        else
            cnt_m = c + 1'b1;
        r.pwm_levels  = pins_m;
        r.claw_event  = claw;
        r.frame_error = err;
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_tick(input logic [NIB_W-1:0] nib, input logic known, input res_t typed);
        res_t predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        port_nibble <= nib;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        step_servo_tick(nib, predicted);
        pending_tick_results.push_back(known ? typed : predicted);
        @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PERIOD_TOP:    top_c    = val;
            REG_PULSE_OFFSET:  offset_c = val;
            REG_PULSE_LIMIT:   limit_c  = val;
            REG_DEADBAND:      db_c     = val[DB_W-1:0];
            REG_SLEW_STEP:     step_c   = val[STEP_W-1:0];
            REG_SLEW_INTERVAL: intv_c   = val[DIV_W-1:0];
            REG_QUIET_LOW:     qlow_c   = val;
            REG_QUIET_HIGH:    qhigh_c  = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_settings(input setup_t kind);
        logic [CNT_W-1:0]  top;
        logic [CNT_W-1:0]  off;
        logic [CNT_W-1:0]  lim;
        logic [CNT_W-1:0]  ql;
        logic [CNT_W-1:0]  qh;
        logic [DB_W-1:0]   db;
        logic [STEP_W-1:0] st;
        logic [DIV_W-1:0]  iv;
        case (kind)
            SETUP_MIN:
            begin
                top = 16'd1000;
                off = '0;
                lim = '0;
                db  = '0;
                st  = 7'd1;
                iv  = 4'd1;
                ql  = '0;
                qh  = '0;
            end
            SETUP_MAX:
            begin
                top = '1;
                off = '1;
                lim = '1;
                db  = '1;
                st  = '1;
                iv  = '1;
                ql  = '1;
                qh  = '1;
            end
            default:
            begin
                top = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(3000, 1000)) : 16'd1000;
                off = CNT_W'($urandom_range(600));
                lim = CNT_W'($urandom_range(2600));
                db  = ($urandom_range(9) == 0) ? 7'd127 : DB_W'($urandom_range(20));
                st  = STEP_W'($urandom_range(127, 1));
                // a zero interval slews on every period end
                iv  = DIV_W'($urandom_range(3));
                ql  = CNT_W'($urandom_range(300));
                qh  = ql + CNT_W'($urandom_range(700));
                if (kind == SETUP_EMPTY_WINDOW)
                begin
                    ql = CNT_W'($urandom_range(900, 500));
                    qh = CNT_W'($urandom_range(int'(ql) - 1));
                end
                // drop the top below the running count to force an early wrap
                if (cnt_m > 16'd1000 && $urandom_range(1) == 1)
                    top = CNT_W'($urandom_range(int'(cnt_m) - 1, 1000));
            end
        endcase
        write_reg(REG_PERIOD_TOP, top);
        write_reg(REG_PULSE_OFFSET, off);
        write_reg(REG_PULSE_LIMIT, lim);
        write_reg(REG_DEADBAND, CNT_W'(db));
        write_reg(REG_SLEW_STEP, CNT_W'(st));
        write_reg(REG_SLEW_INTERVAL, CNT_W'(iv));
        write_reg(REG_QUIET_LOW, ql);
        write_reg(REG_QUIET_HIGH, qh);
    endtask

    function automatic logic [1:0] link_pair();
        return ($urandom_range(99) < 8) ? 2'b11 : 2'($urandom_range(2));
    endfunction

    // Follow the predicted link phase so most nibbles build valid frames.
    task automatic pick_nibble(output logic [NIB_W-1:0] nib);
        if ($urandom_range(99) < 12)
            nib = NIB_W'($urandom_range(15));
        else
        begin
            case (phase_m)
                PH_ROLL: nib = {link_pair(), link_pair()};
                PH_CLAW: nib = {link_pair(), NIB_LOW[1:0]};
                default: nib = {NIB_STROBE[3:2], link_pair()};
            endcase
        end
    endtask

    // Drop valid and wait until every tick has produced its result beat.
    task automatic drain_ticks();
        in_valid <= 1'b0;
        while (pending_tick_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tick_results.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("unexpected result beat at %0t: pwm %b claw %0d err %b",
                             $time, pwm_levels, claw_event, frame_error);
            end
            else
            begin
                want = pending_tick_results.pop_front();
                if (want.pwm_levels !== pwm_levels || want.claw_event !== claw_event ||
                    want.frame_error !== frame_error)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("mismatch at %0t: expected %b/%0d/%b, got %b/%0d/%b",
                                 $time, want.pwm_levels, want.claw_event, want.frame_error,
                                 pwm_levels, claw_event, frame_error);
                end
            end
        end
    end

    initial
    begin : receiver
        int   hold_left;
        logic hold_done;
        out_stall = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            // start the long hold once, when the stimulus asks for it
            if (hold_go === 1'b1 && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int sp;
        int n;
        logic [NIB_W-1:0] nib;
        setup_t kind;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        port_nibble    = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        bad_beats      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go        = 1'b0;
        reset_servo_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (n = 0; n < DIRECTED_COUNT; n++)
            send_tick(DIRECTED_TICKS[n].nib, DIRECTED_TICKS[n].known, DIRECTED_TICKS[n].res);

        for (sp = 0; sp < RANDOM_PHASES; sp++)
        begin
            drain_ticks();
            case (sp)
                1:       kind = SETUP_MIN;
                3:       kind = SETUP_EMPTY_WINDOW;
                4:       kind = SETUP_MAX;
                default: kind = SETUP_RANDOM;
            endcase
            load_settings(kind);
            cfg_valid <= 1'b0;
            case (sp % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            // hold the output while ticks keep coming, so the input backs up
            if (sp == 2)
                hold_go = 1'b1;
            for (n = 0; n < TICKS_PER_PHASE; n++)
            begin
                pick_nibble(nib);
                send_tick(nib, 1'b0, NO_RES);
            end
        end

        drain_ticks();
        repeat (4) @(posedge clk);
        if (bad_beats == 0 && pending_tick_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
